>>> hw/rtl/pscr_pkg.sv
// shared types and constants for the packed saturating counter ring
package pscr_pkg;

   localparam int unsigned REGION_BYTES_DEFAULT       = 1024;
   localparam int unsigned LENGTH_GRAIN_SHIFT_DEFAULT = 3;
   localparam int unsigned QUEUE_DEPTH                = 2;

   localparam int unsigned BYTES_W = 17;
   localparam int unsigned DAY_W   = 16;

   localparam logic [1:0] OP_FORMAT = 2'd0;
   localparam logic [1:0] OP_RECORD = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [15:0]        card_index;
      logic signed [7:0]  increment;
      logic               too_large;
      logic [1:0]         width_log;
      logic [BYTES_W-1:0] bytes;
      logic [DAY_W-1:0]   day;
   } cmd_type;

endpackage

>>> hw/rtl/pscr_front.sv
// front end: takes commands, sizes format windows, converts time to days
module pscr_front #(
   parameter int unsigned REGION_BYTES       = pscr_pkg::REGION_BYTES_DEFAULT,
   parameter int unsigned LENGTH_GRAIN_SHIFT = pscr_pkg::LENGTH_GRAIN_SHIFT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [15:0]           req_card_index,
   input  logic signed [7:0]     req_increment,
   input  logic [15:0]           req_card_count,
   input  logic [7:0]            req_requested_width,
   input  logic [31:0]           req_timestamp,
   input  logic                  done,
   output logic                  push_valid,
   input  logic                  push_ready,
   output pscr_pkg::cmd_type     push_data
);

   localparam logic [25:0] DAY_RECIP = 26'd50903317;

   logic              busy_ff, busy_in;
   logic              stage_valid_ff, stage_valid_in;
   logic [1:0]        opcode_ff;
   logic [15:0]       card_index_ff;
   logic signed [7:0] increment_ff;
   logic [15:0]       card_count_ff;
   logic [7:0]        req_width_ff;
   logic [31:0]       timestamp_ff;

   logic              accept;
   logic [1:0]        width_log;
   logic [18:0]       bit_total;
   logic [19:0]       byte_sum;
   logic [17:0]       bytes_raw;
   logic [17:0]       bytes_up;
   logic [17:0]       bytes_rnd;
   logic [50:0]       day_product;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      if (req_width_ff <= 8'd1) begin
         width_log = 2'd0;
      end else if (req_width_ff == 8'd2) begin
         width_log = 2'd1;
      end else if (req_width_ff <= 8'd4) begin
         width_log = 2'd2;
      end else begin
         width_log = 2'd3;
      end
   end

   assign bit_total   = {3'b000, card_count_ff} << width_log;
   assign byte_sum    = {1'b0, bit_total} + 20'd7;
   assign bytes_raw   = byte_sum[19:3] == 17'd0 ? 18'd0 : {1'b0, byte_sum[19:3]};
   assign bytes_up    = bytes_raw + 18'((1 << LENGTH_GRAIN_SHIFT) - 1);
   assign bytes_rnd   = (bytes_up >> LENGTH_GRAIN_SHIFT) << LENGTH_GRAIN_SHIFT;
   assign day_product = 51'(timestamp_ff[31:7]) * 51'(DAY_RECIP);

   always_comb begin
      push_data.opcode     = opcode_ff;
      push_data.card_index = card_index_ff;
      push_data.increment  = increment_ff;
      push_data.too_large  = bytes_rnd > 18'(REGION_BYTES);
      push_data.width_log  = width_log;
      push_data.bytes      = bytes_rnd[pscr_pkg::BYTES_W-1:0];
      push_data.day        = day_product[50:35];
   end

   assign push_valid = stage_valid_ff;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff     <= req_opcode;
         card_index_ff <= req_card_index;
         increment_ff  <= req_increment;
         card_count_ff <= req_card_count;
         req_width_ff  <= req_requested_width;
         timestamp_ff  <= req_timestamp;
      end
   end

endmodule

>>> hw/rtl/pscr_queue.sv
// short command queue between front end and back end
module pscr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  pscr_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output pscr_pkg::cmd_type pop_data
);

   localparam int unsigned DEPTH = pscr_pkg::QUEUE_DEPTH;
   localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW    = $clog2(DEPTH + 1);

   pscr_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/pscr_back.sv
// back end: window state, ring memory, record, query and window clearing
module pscr_back #(
   parameter int unsigned REGION_BYTES = pscr_pkg::REGION_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  pscr_pkg::cmd_type pop_data,
   output logic              rsp_valid,
   output logic              rsp_status,
   output logic [7:0]        rsp_count_value
);

   localparam int unsigned AW = $clog2(REGION_BYTES);
   localparam int unsigned LW = $clog2(REGION_BYTES + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MODIFY = 2'd1;
   localparam logic [1:0] ST_CLEAR  = 2'd2;

   logic [7:0] ring_mem [REGION_BYTES];
   logic [7:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   logic [1:0]               state_ff, state_in;
   logic [AW-1:0]            start_ff, start_in;
   logic [LW-1:0]            length_ff, length_in;
   logic [1:0]               width_log_ff, width_log_in;
   logic [pscr_pkg::DAY_W-1:0] day_ff, day_in;
   logic [AW-1:0]            clr_addr_ff, clr_addr_in;
   logic [LW-1:0]            clr_left_ff, clr_left_in;
   logic [AW-1:0]            acc_addr_ff, acc_addr_in;
   logic [2:0]               acc_bit_ff, acc_bit_in;
   logic                     acc_query_ff, acc_query_in;
   logic signed [7:0]        acc_inc_ff, acc_inc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_status_ff, rsp_status_in;
   logic [7:0]               rsp_count_ff, rsp_count_in;

   logic              pop;
   logic [18:0]       card_bits;
   logic [15:0]       card_off;
   logic              in_window;
   logic [AW+1:0]     acc_sum;
   logic [AW-1:0]     acc_addr;
   logic [AW+1:0]     start_sum;
   logic [AW-1:0]     new_start;
   logic [7:0]        mask;
   logic [7:0]        cur;
   logic signed [9:0] sat_sum;
   logic [7:0]        sat_val;
   logic [7:0]        new_byte;

   assign pop_ready = state_ff == ST_IDLE;
   assign pop       = pop_valid && pop_ready;

   assign card_bits = {3'b000, pop_data.card_index} << width_log_ff;
   assign card_off  = card_bits[18:3];
   assign in_window = 18'(card_off) < 18'(length_ff);
   assign acc_sum   = (AW + 2)'(start_ff) + (AW + 2)'(card_off);
   assign acc_addr  = (acc_sum >= (AW + 2)'(REGION_BYTES))
                      ? AW'(acc_sum - (AW + 2)'(REGION_BYTES)) : acc_sum[AW-1:0];
   assign start_sum = (AW + 2)'(start_ff) + (AW + 2)'(length_ff);
   assign new_start = (start_sum >= (AW + 2)'(REGION_BYTES))
                      ? AW'(start_sum - (AW + 2)'(REGION_BYTES)) : start_sum[AW-1:0];

   assign rd_addr = acc_addr;

   assign mask    = 8'((9'd1 << (4'd1 << width_log_ff)) - 9'd1);
   assign cur     = (rd_data_ff >> acc_bit_ff) & mask;
   assign sat_sum = $signed({2'b00, cur}) + 10'(acc_inc_ff);
   always_comb begin
      if (sat_sum < 10'sd0) begin
         sat_val = 8'd0;
      end else if (sat_sum > $signed({2'b00, mask})) begin
         sat_val = mask;
      end else begin
         sat_val = sat_sum[7:0];
      end
   end
   assign new_byte = (rd_data_ff & ~(mask << acc_bit_ff)) | (sat_val << acc_bit_ff);

   always_comb begin
      state_in      = state_ff;
      start_in      = start_ff;
      length_in     = length_ff;
      width_log_in  = width_log_ff;
      day_in        = day_ff;
      clr_addr_in   = clr_addr_ff;
      clr_left_in   = clr_left_ff;
      acc_addr_in   = acc_addr_ff;
      acc_bit_in    = acc_bit_ff;
      acc_query_in  = acc_query_ff;
      acc_inc_in    = acc_inc_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = 1'b0;
      rsp_count_in  = 8'd0;
      mem_we        = 1'b0;
      mem_waddr     = clr_addr_ff;
      mem_wdata     = 8'd0;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (pop_data.opcode)
                  pscr_pkg::OP_FORMAT: begin
                     if (pop_data.too_large) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = 1'b1;
                     end else begin
                        start_in     = new_start;
                        length_in    = LW'(pop_data.bytes);
                        width_log_in = pop_data.width_log;
                        day_in       = pop_data.day;
                        clr_addr_in  = new_start;
                        clr_left_in  = LW'(pop_data.bytes);
                        if (pop_data.bytes == '0) begin
                           rsp_valid_in = 1'b1;
                        end else begin
                           state_in = ST_CLEAR;
                        end
                     end
                  end
                  pscr_pkg::OP_RECORD, pscr_pkg::OP_QUERY: begin
                     if (!in_window) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = 1'b1;
                     end else begin
                        acc_addr_in  = acc_addr;
                        acc_bit_in   = card_bits[2:0];
                        acc_query_in = pop_data.opcode == pscr_pkg::OP_QUERY;
                        acc_inc_in   = pop_data.increment;
                        state_in     = ST_MODIFY;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MODIFY: begin
            rsp_valid_in = 1'b1;
            if (acc_query_ff) begin
               rsp_count_in = cur;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = acc_addr_ff;
               mem_wdata = new_byte;
            end
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = (clr_addr_ff == AW'(REGION_BYTES - 1)) ? '0 : clr_addr_ff + 1'b1;
            clr_left_in = clr_left_ff - 1'b1;
            if (clr_left_ff == LW'(1)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         length_ff    <= '0;
         width_log_ff <= 2'd0;
         day_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         length_ff    <= length_in;
         width_log_ff <= width_log_in;
         day_ff       <= day_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_addr_ff   <= clr_addr_in;
      clr_left_ff   <= clr_left_in;
      acc_addr_ff   <= acc_addr_in;
      acc_bit_ff    <= acc_bit_in;
      acc_query_ff  <= acc_query_in;
      acc_inc_ff    <= acc_inc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff & rsp_valid_ff;
   assign rsp_count_value = rsp_count_ff;

endmodule

>>> hw/rtl/packed_saturating_counter_ring.sv
// packed saturating counter ring: top level
// A command is taken when start is high and busy is low; busy then stays high
// until the single result beat has been shown on rsp_valid for one cycle, and
// the receiver cannot stall it. A record or query inside the window passes
// the front stage, the queue, one memory read and, for a record, one write
// back before its result. A record or query outside the window, an oversized
// or empty format and the unused opcode skip the memory steps. Any other
// format also clears the new window, one byte per cycle, through the single
// memory write port.
module packed_saturating_counter_ring #(
   parameter int unsigned REGION_BYTES       = pscr_pkg::REGION_BYTES_DEFAULT,
   parameter int unsigned LENGTH_GRAIN_SHIFT = pscr_pkg::LENGTH_GRAIN_SHIFT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [15:0]       req_card_index,
   input  logic signed [7:0] req_increment,
   input  logic [15:0]       req_card_count,
   input  logic [7:0]        req_requested_width,
   input  logic [31:0]       req_timestamp,
   output logic              rsp_valid,
   output logic              rsp_status,
   output logic [7:0]        rsp_count_value
);

   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   pscr_pkg::cmd_type push_data, pop_data;

   pscr_front #(
      .REGION_BYTES       (REGION_BYTES),
      .LENGTH_GRAIN_SHIFT (LENGTH_GRAIN_SHIFT)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_card_index      (req_card_index),
      .req_increment       (req_increment),
      .req_card_count      (req_card_count),
      .req_requested_width (req_requested_width),
      .req_timestamp       (req_timestamp),
      .done                (rsp_valid),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_data           (push_data)
   );

   pscr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pscr_back #(
      .REGION_BYTES (REGION_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_count_value (rsp_count_value)
   );

endmodule

>>> test/packed_saturating_counter_ring_tb.sv
// self-checking testbench for the packed saturating counter ring
module packed_saturating_counter_ring_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned REGION      = pscr_pkg::REGION_BYTES_DEFAULT;
   localparam int unsigned GRAIN_SHIFT = pscr_pkg::LENGTH_GRAIN_SHIFT_DEFAULT;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;
   localparam int          RANDOM_CMDS = 1300;
   localparam int          TAIL_CMDS   = 150;
   localparam int unsigned DAY_SECONDS = 86400;

   typedef struct {
      logic [1:0]        op;
      logic [15:0]       card;
      logic signed [7:0] delta;
      logic [15:0]       cards;
      logic [7:0]        width_req;
      logic [31:0]       stamp;
      bit                drain;
   } cmd_item_type;

   typedef struct {
      logic       status;
      logic [7:0] count;
   } reply_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_opcode = '0;
   logic [15:0]       req_card_index = '0;
   logic signed [7:0] req_increment = '0;
   logic [15:0]       req_card_count = '0;
   logic [7:0]        req_requested_width = '0;
   logic [31:0]       req_timestamp = '0;
   logic              rsp_valid;
   logic              rsp_status;
   logic [7:0]        rsp_count_value;

   cmd_item_type command_queue[$];
   reply_type    pending_replies[$];
   cmd_item_type cur_cmd;

   logic [7:0]  ring_bytes[REGION];
   int unsigned win_start = 0;
   int unsigned win_len = 0;
   int unsigned cnt_width = 1;
   logic [15:0] fmt_day = '0;

   int unsigned gen_len = 0;
   int unsigned gen_w = 1;

   int gap_left = 0;
   int idle_pct = 25;
   int accepted_total = 0;
   int replies_seen = 0;
   int errors = 0;

   packed_saturating_counter_ring DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_card_index(req_card_index),
      .req_increment(req_increment),
      .req_card_count(req_card_count),
      .req_requested_width(req_requested_width),
      .req_timestamp(req_timestamp),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_count_value(rsp_count_value)
   );

   always #2 clock = ~clock;

   function automatic int unsigned round_width(input int unsigned req);
      if (req == 0) return 1;
      if (req <= 2) return req;
      if (req <= 4) return 4;
      return 8;
   endfunction

   function automatic int unsigned window_bytes(input int unsigned cards, input int unsigned w);
      int unsigned nbytes;
      int unsigned grain;
      grain = 1 << GRAIN_SHIFT;
      nbytes = (cards * w + 7) >> 3;
      return (nbytes + grain - 1) & ~(grain - 1);
   endfunction

   // advances the counter ring state by one command and queues its reply
   function automatic void apply_command(input cmd_item_type c);
      int unsigned w, nbytes, bits, off, addr, mask, cur, bit_pos, i;
      int          v;
      reply_type   r;
      r.status = 1'b0;
      r.count = '0;
      case (c.op)
         pscr_pkg::OP_FORMAT: begin
            w = round_width(32'(c.width_req));
            nbytes = window_bytes(32'(c.cards), w);
            if (nbytes > REGION) begin
               r.status = 1'b1;
            end else begin
               win_start = win_start + win_len;
               if (win_start >= REGION) win_start = win_start - REGION;
               win_len = nbytes;
               cnt_width = w;
               fmt_day = 16'(c.stamp / DAY_SECONDS);
               addr = win_start;
               for (i = 0; i < nbytes; i++) begin
                  ring_bytes[addr] = '0;
                  addr = (addr + 1 >= REGION) ? 0 : addr + 1;
               end
            end
         end
         pscr_pkg::OP_RECORD, pscr_pkg::OP_QUERY: begin
            bits = c.card * cnt_width;
            off = bits >> 3;
            if (off >= win_len) begin
               r.status = 1'b1;
            end else begin
               bit_pos = bits & 7;
               addr = win_start + off;
               if (addr >= REGION) addr = addr - REGION;
               mask = (1 << cnt_width) - 1;
               cur = (ring_bytes[addr] >> bit_pos) & mask;
               if (c.op == pscr_pkg::OP_QUERY) begin
                  r.count = 8'(cur);
               end else begin
                  v = int'(cur) + int'(c.delta);
                  if (v < 0) v = 0;
                  if (v > int'(mask)) v = int'(mask);
                  ring_bytes[addr] = 8'((ring_bytes[addr] & ~(mask << bit_pos))
                                        | (v << bit_pos));
               end
            end
         end
         default: begin
         end
      endcase
      pending_replies.push_back(r);
   endfunction

   function automatic void add_cmd(input logic [1:0] op, input logic [15:0] card,
                                   input logic signed [7:0] delta, input logic [15:0] cards,
                                   input logic [7:0] width_req, input logic [31:0] stamp,
                                   input bit drain);
      cmd_item_type c;
      int unsigned  w, nbytes;
      c.op = op;
      c.card = card;
      c.delta = delta;
      c.cards = cards;
      c.width_req = width_req;
      c.stamp = stamp;
      c.drain = drain;
      command_queue.push_back(c);
      if (op == pscr_pkg::OP_FORMAT) begin
         w = round_width(32'(width_req));
         nbytes = window_bytes(32'(cards), w);
         if (nbytes <= REGION) begin
            gen_len = nbytes;
            gen_w = w;
         end
      end
   endfunction

   task automatic report(input string msg);
      $display("%0t ns mismatch: %s", $realtime, msg);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      logic fire;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         fire = start && !busy;
         if (fire) begin
            apply_command(cur_cmd);
            accepted_total++;
            if (accepted_total % 100 == 0)
               idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
         end
         if (!start || fire) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (fire && command_queue.size() > TAIL_CMDS
                         && $urandom_range(0, 99) < idle_pct) begin
               gap_left <= $urandom_range(0, 11);
               start <= 1'b0;
            end else if (command_queue.size() != 0
                         && !(command_queue[0].drain && accepted_total != replies_seen)) begin
               cur_cmd = command_queue.pop_front();
               req_opcode <= cur_cmd.op;
               req_card_index <= cur_cmd.card;
               req_increment <= cur_cmd.delta;
               req_card_count <= cur_cmd.cards;
               req_requested_width <= cur_cmd.width_req;
               req_timestamp <= cur_cmd.stamp;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid) begin
         replies_seen <= replies_seen + 1;
         if (pending_replies.size() == 0) begin
            report($sformatf("unexpected beat status=%0d count=%0d",
                             rsp_status, rsp_count_value));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status)
               report($sformatf("status got %0d want %0d", rsp_status, want.status));
            if (rsp_count_value !== want.count)
               report($sformatf("count got %0d want %0d", rsp_count_value, want.count));
         end
      end
   end

   initial begin
      int unsigned r, w, gen_cards;
      logic [1:0]        op;
      logic [15:0]       card, cards;
      logic signed [7:0] delta;
      logic [7:0]        wreq;

      // empty window, unused opcode
      add_cmd(pscr_pkg::OP_QUERY, 16'd0, 8'sd0, 16'd0, 8'd0, 32'd0, 1'b0);
      add_cmd(pscr_pkg::OP_RECORD, 16'hFFFF, 8'sd127, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 1'b0);
      add_cmd(OP_UNUSED, 16'hFFFF, -8'sd1, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 1'b0);
      // one bit counters, saturation both ways, window edge
      add_cmd(pscr_pkg::OP_FORMAT, 16'd0, 8'sd0, 16'd64, 8'd0, 32'd0, 1'b0);
      add_cmd(pscr_pkg::OP_RECORD, 16'd0, 8'sd127, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_QUERY, 16'd0, 8'sd0, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_RECORD, 16'd63, -8'sd128, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_QUERY, 16'd63, 8'sd0, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_QUERY, 16'd64, 8'sd0, 16'd0, 8'd0, $urandom, 1'b0);
      // oversized windows, empty window
      add_cmd(pscr_pkg::OP_FORMAT, 16'd0, 8'sd0, 16'hFFFF, 8'hFF, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_FORMAT, 16'd0, 8'sd0, 16'd1025, 8'd8, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_FORMAT, 16'd0, 8'sd0, 16'd0, 8'd2, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_RECORD, 16'd0, 8'sd1, 16'd0, 8'd0, $urandom, 1'b0);
      // nibble counters
      add_cmd(pscr_pkg::OP_FORMAT, 16'd0, 8'sd0, 16'd16, 8'd3, 32'hFFFFFFFF, 1'b0);
      add_cmd(pscr_pkg::OP_RECORD, 16'd15, 8'sd7, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_RECORD, 16'd15, 8'sd100, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_QUERY, 16'd15, 8'sd0, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_RECORD, 16'd15, -8'sd128, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_QUERY, 16'd15, 8'sd0, 16'd0, 8'd0, $urandom, 1'b0);
      // full ring of byte counters, wrapping addresses
      add_cmd(pscr_pkg::OP_FORMAT, 16'd0, 8'sd0, 16'd1024, 8'd5, $urandom, 1'b1);
      add_cmd(pscr_pkg::OP_RECORD, 16'd1023, 8'sd127, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_RECORD, 16'd1023, 8'sd127, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_RECORD, 16'd1023, 8'sd1, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_QUERY, 16'd1023, 8'sd0, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_QUERY, 16'd0, 8'sd0, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_FORMAT, 16'd0, 8'sd0, 16'd40, 8'd1, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_RECORD, 16'd39, 8'sd1, 16'd0, 8'd0, $urandom, 1'b0);
      add_cmd(pscr_pkg::OP_QUERY, 16'd39, 8'sd0, 16'd0, 8'd0, $urandom, 1'b0);

      for (int n = 0; n < RANDOM_CMDS; n++) begin
         card = 16'($urandom);
         delta = 8'($urandom);
         cards = 16'($urandom);
         wreq = 8'($urandom);
         gen_cards = gen_len * 8 / gen_w;
         r = $urandom_range(0, 99);
         if (r < 6) begin
            op = pscr_pkg::OP_FORMAT;
            if ($urandom_range(0, 1) == 0) wreq = 8'($urandom_range(0, 5));
            w = round_width(32'(wreq));
            r = $urandom_range(0, 99);
            if (r < 75) cards = 16'($urandom_range(0, 512 / w));
            else if (r < 85) cards = 16'($urandom_range(0, REGION * 8 / w));
         end else if (r < 9) begin
            op = OP_UNUSED;
         end else begin
            op = ($urandom_range(0, 99) < 60) ? pscr_pkg::OP_RECORD : pscr_pkg::OP_QUERY;
            r = $urandom_range(0, 99);
            if (gen_cards != 0 && r < 85) card = 16'($urandom_range(0, gen_cards - 1));
            else if (r < 92) card = 16'(gen_cards + $urandom_range(0, 7));
            if ($urandom_range(0, 1) == 0) delta = 8'(int'($urandom_range(0, 6)) - 3);
         end
         add_cmd(op, card, delta, cards, wreq, $urandom, $urandom_range(0, 299) == 0);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (command_queue.size() != 0 || start || pending_replies.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
